// ----- src/cpa_pkg.sv -----
package cpa_pkg;

   localparam int MAP_PAGES_DEF = 4096;

   localparam int ADDR_W     = 56;
   localparam int COUNT_W    = 13;
   localparam int STATUS_W   = 3;
   localparam int PAGE_SHIFT = 12;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = ((COUNT_W + ADDR_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((STATUS_W + ADDR_W + 7) / 8) * 8;

   // per-page mark bits
   localparam logic [1:0] MARK_TAKEN = 2'b01;
   localparam logic [1:0] MARK_LAST  = 2'b10;

   // request kinds
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_NO_SPACE     = 3'd1,
      ST_ZERO_COUNT   = 3'd2,
      ST_OUT_OF_RANGE = 3'd3,
      ST_UNTERMINATED = 3'd4
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic       clr_wr;
      logic       capture;
      logic       prime;
      logic       scan;
      logic       mark;
      logic       free_chk;
      logic       walk;
      logic       set_status;
      status_type status;
      logic       load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_zero;
      logic count_big;
      logic found;
      logic chk_last;
      logic ptr_last;
      logic mark_done;
      logic range_bad;
      logic pg_taken;
      logic pg_last;
   } sts_type;

endpackage

// ----- src/cpa_dpath.sv -----
module cpa_dpath #(
   parameter int MAP_PAGES = cpa_pkg::MAP_PAGES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cpa_pkg::cmd_type                 cmd,
   output cpa_pkg::sts_type                 sts,
   input  logic                             req_op,
   input  logic [cpa_pkg::COUNT_W-1:0]      req_count,
   input  logic [cpa_pkg::ADDR_W-1:0]       req_address,
   input  logic                             csr_we,
   input  logic [cpa_pkg::ADDR_W-1:0]       csr_wdata,
   output cpa_pkg::status_type              rsp_status,
   output logic [cpa_pkg::ADDR_W-1:0]       rsp_address
);

   localparam int IDX_W  = $clog2(MAP_PAGES);
   localparam int CNT_W  = $clog2(MAP_PAGES + 1);
   localparam int CMP_W  = (CNT_W > cpa_pkg::COUNT_W) ? CNT_W : cpa_pkg::COUNT_W;
   localparam int PAGE_W = cpa_pkg::ADDR_W - cpa_pkg::PAGE_SHIFT;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAP_PAGES - 1);

   logic [1:0]                   mem [MAP_PAGES];
   logic [1:0]                   rd_data_ff;
   logic [IDX_W-1:0]             chk_ff;
   logic [IDX_W-1:0]             ptr_ff, ptr_in;
   logic [CNT_W-1:0]             run_ff;
   logic [IDX_W-1:0]             start_ff, end_ff;
   logic                         op_ff;
   logic [cpa_pkg::COUNT_W-1:0]  count_ff;
   logic [cpa_pkg::ADDR_W-1:0]   addr_ff;
   logic [cpa_pkg::ADDR_W-1:0]   base_ff;
   cpa_pkg::status_type          status_ff;
   cpa_pkg::status_type          rsp_status_ff;
   logic [cpa_pkg::ADDR_W-1:0]   rsp_address_ff;

   logic                         ptr_last, pg_taken, pg_last, found, mark_done;
   logic [IDX_W-1:0]             ptr_inc, scan_start;
   logic [CNT_W-1:0]             run_nx;
   logic [cpa_pkg::ADDR_W-1:0]   diff, result_address;
   logic [PAGE_W-1:0]            page;
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic [1:0]                   wr_data;

   assign ptr_last   = (ptr_ff == LAST_IDX);
   assign ptr_inc    = ptr_last ? ptr_ff : ptr_ff + 1'b1;
   assign pg_taken   = |(rd_data_ff & cpa_pkg::MARK_TAKEN);
   assign pg_last    = |(rd_data_ff & cpa_pkg::MARK_LAST);
   assign run_nx     = run_ff + 1'b1;
   assign found      = !pg_taken && (CMP_W'(run_nx) == CMP_W'(count_ff));
   assign scan_start = chk_ff - run_ff[IDX_W-1:0];
   assign mark_done  = (ptr_ff == end_ff);
   assign diff       = addr_ff - base_ff;
   assign page       = diff[cpa_pkg::ADDR_W-1:cpa_pkg::PAGE_SHIFT];
   assign result_address = base_ff + (cpa_pkg::ADDR_W'(start_ff) << cpa_pkg::PAGE_SHIFT);

   always_comb begin
      sts.count_zero = (count_ff == '0);
      sts.count_big  = (CMP_W'(count_ff) > CMP_W'(MAP_PAGES));
      sts.found      = found;
      sts.chk_last   = (chk_ff == LAST_IDX);
      sts.ptr_last   = ptr_last;
      sts.mark_done  = mark_done;
      sts.range_bad  = (addr_ff < base_ff) || (page >= PAGE_W'(MAP_PAGES));
      sts.pg_taken   = pg_taken;
      sts.pg_last    = pg_last;
   end

   // single write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = '0;
      if (cmd.clr_wr) begin
         wr_en = 1'b1;
      end else if (cmd.mark) begin
         wr_en   = 1'b1;
         wr_data = mark_done ? (cpa_pkg::MARK_TAKEN | cpa_pkg::MARK_LAST)
                             : cpa_pkg::MARK_TAKEN;
      end else if (cmd.walk) begin
         wr_en   = pg_taken || pg_last;
         wr_addr = chk_ff;
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.capture) begin
         ptr_in = '0;
      end else if (cmd.free_chk) begin
         ptr_in = page[IDX_W-1:0];
      end else if (cmd.scan && found) begin
         ptr_in = scan_start;
      end else if (cmd.clr_wr || cmd.prime || cmd.scan || cmd.mark || cmd.walk) begin
         ptr_in = ptr_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[ptr_ff];
      chk_ff     <= ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         base_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
         if (csr_we) begin
            base_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         count_ff <= req_count;
         addr_ff  <= req_address;
         run_ff   <= '0;
      end else if (cmd.scan) begin
         run_ff <= pg_taken ? '0 : run_nx;
      end
      if (cmd.scan && found) begin
         start_ff <= scan_start;
         end_ff   <= chk_ff;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.load_out) begin
         rsp_status_ff  <= status_ff;
         rsp_address_ff <= (status_ff == cpa_pkg::ST_OK && op_ff == cpa_pkg::OP_ALLOC)
                           ? result_address : '0;
      end
   end

   assign rsp_status  = rsp_status_ff;
   assign rsp_address = rsp_address_ff;

endmodule

// ----- src/cpa_ctrl.sv -----
module cpa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_op,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  cpa_pkg::sts_type sts,
   output cpa_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      CLEAR,
      IDLE,
      ALLOC_CHECK,
      ALLOC_SCAN,
      ALLOC_MARK,
      FREE_CHECK,
      FREE_PRIME,
      FREE_WALK,
      RESP
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      cmd.status   = cpa_pkg::ST_OK;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.ptr_last) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.capture = 1'b1;
               state_in = (req_op == cpa_pkg::OP_FREE) ? FREE_CHECK : ALLOC_CHECK;
            end
         end
         ALLOC_CHECK: begin
            if (sts.count_zero) begin
               cmd.set_status = 1'b1;
               cmd.status     = cpa_pkg::ST_ZERO_COUNT;
               state_in       = RESP;
            end else if (sts.count_big) begin
               cmd.set_status = 1'b1;
               cmd.status     = cpa_pkg::ST_NO_SPACE;
               state_in       = RESP;
            end else begin
               cmd.prime = 1'b1;
               state_in  = ALLOC_SCAN;
            end
         end
         ALLOC_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.found) begin
               state_in = ALLOC_MARK;
            end else if (sts.chk_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = cpa_pkg::ST_NO_SPACE;
               state_in       = RESP;
            end
         end
         ALLOC_MARK: begin
            cmd.mark = 1'b1;
            if (sts.mark_done) begin
               cmd.set_status = 1'b1;
               cmd.status     = cpa_pkg::ST_OK;
               state_in       = RESP;
            end
         end
         FREE_CHECK: begin
            if (sts.range_bad) begin
               cmd.set_status = 1'b1;
               cmd.status     = cpa_pkg::ST_OUT_OF_RANGE;
               state_in       = RESP;
            end else begin
               cmd.free_chk = 1'b1;
               state_in     = FREE_PRIME;
            end
         end
         FREE_PRIME: begin
            cmd.prime = 1'b1;
            state_in  = FREE_WALK;
         end
         FREE_WALK: begin
            cmd.walk = 1'b1;
            if (sts.pg_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = cpa_pkg::ST_OK;
               state_in       = RESP;
            end else if (!sts.pg_taken || sts.chk_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = cpa_pkg::ST_UNTERMINATED;
               state_in       = RESP;
            end
         end
         RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= (state_in == IDLE);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = ready_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- src/contiguous_page_allocator_top.sv -----
// allocate: check the page count, scan the mark memory first-fit for a free run, then
// mark the pages of the run found; free: range check, then walk and clear the pages of the run
// up to the page marked last; a rejected request goes straight to the response
// one request at a time; the scan and the free walk step over the mark memory one page per cycle
// reset: synchronous; afterwards a clearing pass zeroes the mark memory
// and req_tready stays low until it finishes; alloc_base resets to zero
module contiguous_page_allocator_top #(
   parameter int MAP_PAGES = cpa_pkg::MAP_PAGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // page_count [12:0], free_address [68:13], zero pad above
   input  logic [cpa_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op: 0 allocate, 1 free
   input  logic                              req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status [2:0], result_address [58:3], zero pad above
   output logic [cpa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // alloc_base register
   input  logic                              csr_we,
   input  logic [cpa_pkg::ADDR_W-1:0]        csr_wdata
);

   localparam int PAD_W = cpa_pkg::RSP_DATA_W - cpa_pkg::ADDR_W - cpa_pkg::STATUS_W;

   cpa_pkg::cmd_type               cmd;
   cpa_pkg::sts_type               sts;
   logic [cpa_pkg::COUNT_W-1:0]    req_count;
   logic [cpa_pkg::ADDR_W-1:0]     req_address;
   cpa_pkg::status_type            rsp_status;
   logic [cpa_pkg::ADDR_W-1:0]     rsp_address;

   // unpack the request beat
   assign req_count   = req_tdata[cpa_pkg::COUNT_W-1:0];
   assign req_address = req_tdata[cpa_pkg::COUNT_W +: cpa_pkg::ADDR_W];

   // sequencer: clearing pass, first-fit scan, marking, free walk, output handoff
   cpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // mark memory, scan counters, address math, output register
   cpa_dpath #(
      .MAP_PAGES (MAP_PAGES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_op      (req_tuser),
      .req_count   (req_count),
      .req_address (req_address),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .rsp_status  (rsp_status),
      .rsp_address (rsp_address)
   );

   // pack the response beat
   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_address, rsp_status};

`ifndef SYNTHESIS
   // datapath steps never overlap
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_wr, cmd.capture, cmd.prime, cmd.scan, cmd.mark,
                cmd.free_chk, cmd.walk, cmd.load_out}))
      else $error("overlapping datapath commands");

   // output register only reloads when its beat is gone or leaving
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_tvalid || rsp_tready))
      else $error("response overwritten");

   // one request in flight: no accept right after an accept
   a_single: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request taken while busy");

   // a new response only comes from an output load
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.load_out))
      else $error("response without load");
`endif

endmodule
